/* hdl/ealu_pkg.sv */
// Shared types and constants for the eight-bit ALU with status flags.
package ealu_pkg;

	// Width of the data path and of the fixed-width request fields.
	localparam int DATA_WIDTH = 8;
	localparam int OPCODE_W   = 4;
	localparam int STATUS_W   = 8;

	// Bit positions of the flags inside the status byte.
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	// Operation codes carried in the opcode field.
	typedef enum logic [OPCODE_W-1:0] {
		OP_ADC  = 4'd0,
		OP_SBC  = 4'd1,
		OP_AND  = 4'd2,
		OP_XOR  = 4'd3,
		OP_OR   = 4'd4,
		OP_CMP  = 4'd5,
		OP_ASL  = 4'd6,
		OP_LSR  = 4'd7,
		OP_ROL  = 4'd8,
		OP_ROR  = 4'd9,
		OP_INC  = 4'd10,
		OP_DEC  = 4'd11,
		OP_SETF = 4'd12,
		OP_CLRF = 4'd13,
		OP_LDF  = 4'd14
	} op_t;

endpackage

/* hdl/ealu_in_if.sv */
// Request channel: opcode, two operands and the current status byte.
interface ealu_in_if #(
	parameter int DATA_WIDTH = ealu_pkg::DATA_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic [ealu_pkg::OPCODE_W-1:0] opcode;
	logic [DATA_WIDTH-1:0]         operand_a;
	logic [DATA_WIDTH-1:0]         operand_b;
	logic [ealu_pkg::STATUS_W-1:0] status_in;

	modport source (
		output valid, opcode, operand_a, operand_b, status_in,
		input  ready
	);

	modport sink (
		input  valid, opcode, operand_a, operand_b, status_in,
		output ready
	);
endinterface

/* hdl/ealu_out_if.sv */
// Result channel: result value, write-back enable and the new status byte.
interface ealu_out_if #(
	parameter int DATA_WIDTH = ealu_pkg::DATA_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic [DATA_WIDTH-1:0]         result;
	logic                          write_result;
	logic [ealu_pkg::STATUS_W-1:0] status_out;

	modport source (
		output valid, result, write_result, status_out,
		input  ready
	);

	modport sink (
		input  valid, result, write_result, status_out,
		output ready
	);
endinterface

/* hdl/eight_bit_alu_with_status_flags.sv */
// The request is captured in the input register, the combinational core computes
// its result, and the result register holds it on out_ch.
// Throughput: one request per cycle while out_ch.ready is high; the input and result
// registers each advance whenever the stage after them is empty or being drained.
// Reset: arst_n clears both stage valid flags at once; in_ch.ready rises on the
// first clock edge after reset is released.
module eight_bit_alu_with_status_flags #(
	parameter int DATA_WIDTH = ealu_pkg::DATA_WIDTH
) (
	input logic clk,
	input logic arst_n,
	ealu_in_if.sink    in_ch,
	ealu_out_if.source out_ch
);
	logic                          ready_en_q;
	logic                          valid_s1;
	logic [ealu_pkg::OPCODE_W-1:0] opcode_s1;
	logic [DATA_WIDTH-1:0]         operand_a_s1;
	logic [DATA_WIDTH-1:0]         operand_b_s1;
	logic [ealu_pkg::STATUS_W-1:0] status_s1;

	logic                          valid_s2;
	logic [DATA_WIDTH-1:0]         result_s2;
	logic                          write_s2;
	logic [ealu_pkg::STATUS_W-1:0] status_s2;

	logic [DATA_WIDTH-1:0]         result_c;
	logic                          write_c;
	logic [ealu_pkg::STATUS_W-1:0] status_c;

	logic adv_s2;
	logic adv_s1;

	// Each stage moves when the stage after it can take its contents.
	assign adv_s2      = ~valid_s2 | out_ch.ready;
	assign adv_s1      = ~valid_s1 | adv_s2;
	assign in_ch.ready = ready_en_q & adv_s1;

	// Ready is held low until the first edge after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_en_q <= 1'b0;
		end else begin
			ready_en_q <= 1'b1;
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_ch.valid & in_ch.ready;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			opcode_s1    <= in_ch.opcode;
			operand_a_s1 <= in_ch.operand_a;
			operand_b_s1 <= in_ch.operand_b;
			status_s1    <= in_ch.status_in;
		end
	end

	ealu_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_core (
		.opcode      (opcode_s1),
		.operand_a   (operand_a_s1),
		.operand_b   (operand_b_s1),
		.status_in   (status_s1),
		.result      (result_c),
		.write_result(write_c),
		.status_out  (status_c)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_c;
			write_s2  <= write_c;
			status_s2 <= status_c;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.result       = result_s2;
	assign out_ch.write_result = write_s2;
	assign out_ch.status_out   = status_s2;
endmodule

/* hdl/ealu_core.sv */
// Combinational ALU: one operation, its result, write enable and flag update.
module ealu_core #(
	parameter int DATA_WIDTH = ealu_pkg::DATA_WIDTH
) (
	input  logic [ealu_pkg::OPCODE_W-1:0] opcode,
	input  logic [DATA_WIDTH-1:0]         operand_a,
	input  logic [DATA_WIDTH-1:0]         operand_b,
	input  logic [ealu_pkg::STATUS_W-1:0] status_in,
	output logic [DATA_WIDTH-1:0]         result,
	output logic                          write_result,
	output logic [ealu_pkg::STATUS_W-1:0] status_out
);
	localparam int MSB = DATA_WIDTH - 1;

	ealu_pkg::op_t         op;
	logic                  c_in;
	logic [DATA_WIDTH-1:0] b_add;
	logic [DATA_WIDTH:0]   sum_w;
	logic [DATA_WIDTH:0]   diff_w;
	logic                  nz_upd;

	assign op   = ealu_pkg::op_t'(opcode);
	assign c_in = status_in[ealu_pkg::FLAG_C];

	// Subtract adds the inverted operand; both share one adder.
	assign b_add  = (op == ealu_pkg::OP_SBC) ? ~operand_b : operand_b;
	assign sum_w  = {1'b0, operand_a} + {1'b0, b_add} + {{DATA_WIDTH{1'b0}}, c_in};
	assign diff_w = {1'b0, operand_a} - {1'b0, operand_b};

	// Decode the operation and form the result and status byte.
	always_comb begin
		result       = '0;
		write_result = 1'b1;
		status_out   = status_in;
		nz_upd       = 1'b1;
		unique case (op)
			ealu_pkg::OP_ADC, ealu_pkg::OP_SBC: begin
				result = sum_w[DATA_WIDTH-1:0];
				status_out[ealu_pkg::FLAG_C] = sum_w[DATA_WIDTH];
				status_out[ealu_pkg::FLAG_V] = (sum_w[MSB] ^ operand_a[MSB]) &
					(sum_w[MSB] ^ b_add[MSB]);
			end
			ealu_pkg::OP_AND: result = operand_a & operand_b;
			ealu_pkg::OP_XOR: result = operand_a ^ operand_b;
			ealu_pkg::OP_OR:  result = operand_a | operand_b;
			ealu_pkg::OP_CMP: begin
				result       = diff_w[DATA_WIDTH-1:0];
				write_result = 1'b0;
				nz_upd       = 1'b0;
				status_out[ealu_pkg::FLAG_C] = ~diff_w[DATA_WIDTH];
				status_out[ealu_pkg::FLAG_Z] = (operand_a == operand_b);
				status_out[ealu_pkg::FLAG_N] = diff_w[MSB];
			end
			ealu_pkg::OP_ASL: begin
				result = {operand_b[MSB-1:0], 1'b0};
				status_out[ealu_pkg::FLAG_C] = operand_b[MSB];
			end
			ealu_pkg::OP_LSR: begin
				result = {1'b0, operand_b[MSB:1]};
				status_out[ealu_pkg::FLAG_C] = operand_b[0];
			end
			ealu_pkg::OP_ROL: begin
				result = {operand_b[MSB-1:0], c_in};
				status_out[ealu_pkg::FLAG_C] = operand_b[MSB];
			end
			ealu_pkg::OP_ROR: begin
				result = {c_in, operand_b[MSB:1]};
				status_out[ealu_pkg::FLAG_C] = operand_b[0];
			end
			ealu_pkg::OP_INC: result = operand_b + DATA_WIDTH'(1);
			ealu_pkg::OP_DEC: result = operand_b - DATA_WIDTH'(1);
			ealu_pkg::OP_SETF: begin
				write_result = 1'b0;
				nz_upd       = 1'b0;
				status_out   = status_in | ealu_pkg::STATUS_W'(operand_b);
			end
			ealu_pkg::OP_CLRF: begin
				write_result = 1'b0;
				nz_upd       = 1'b0;
				status_out   = status_in & ~(ealu_pkg::STATUS_W'(operand_b));
			end
			ealu_pkg::OP_LDF: begin
				result       = operand_b;
				write_result = 1'b0;
			end
			default: begin
				// The unused code leaves everything as it was.
				write_result = 1'b0;
				nz_upd       = 1'b0;
			end
		endcase

		// Sign and zero follow the result for most operations.
		if (nz_upd) begin
			status_out[ealu_pkg::FLAG_N] = result[MSB];
			status_out[ealu_pkg::FLAG_Z] = (result == '0);
		end
	end
endmodule

/* hdl/ealu_checker.sv */
// Port-level checks for the ALU: flow control, latency and reset.
module ealu_checker #(
	parameter int DATA_WIDTH = ealu_pkg::DATA_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [DATA_WIDTH-1:0]         result,
	input logic                          write_result,
	input logic [ealu_pkg::STATUS_W-1:0] status_out
);
	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) &&
			$stable(write_result) && $stable(status_out))
		else $error("stalled result changed or vanished");

	// An accepted request is followed by out_valid after the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted request produced no result");

	// Out of reset, requests are refused only when both stages are full and stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && !in_ready |-> out_valid && !out_ready)
		else $error("request refused while the pipeline had room");

	// Nothing is offered on the first edge after reset.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_ready)
		else $error("output valid or ready right after reset");
endmodule

bind eight_bit_alu_with_status_flags ealu_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_ealu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.result      (out_ch.result),
	.write_result(out_ch.write_result),
	.status_out  (out_ch.status_out)
);

/* tb/eight_bit_alu_with_status_flags_tb.sv */
module eight_bit_alu_with_status_flags_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = ealu_pkg::DATA_WIDTH;
	localparam int OPCODE_W = ealu_pkg::OPCODE_W;
	localparam int STATUS_W = ealu_pkg::STATUS_W;
	localparam int FLAG_C = ealu_pkg::FLAG_C;
	localparam int FLAG_Z = ealu_pkg::FLAG_Z;
	localparam int FLAG_V = ealu_pkg::FLAG_V;
	localparam int FLAG_N = ealu_pkg::FLAG_N;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;
	// The one opcode value that the operation set leaves unused.
	localparam logic [OPCODE_W-1:0] OPCODE_UNUSED = 4'hF;

	typedef struct packed {
		logic [DW-1:0]       value;
		logic                writes;
		logic [STATUS_W-1:0] flags;
	} alu_outcome_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [DW-1:0]       a;
		logic [DW-1:0]       b;
		logic [STATUS_W-1:0] st;
		alu_outcome_t        outcome;
	} pending_request_t;

	logic clk;
	logic arst_n;
	logic idle_enabled;
	int   error_count;
	int   cycle_count;

	pending_request_t pending_outcomes[$];

	ealu_in_if  in_ch();
	ealu_out_if out_ch();

	eight_bit_alu_with_status_flags uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Expected outcome of one ALU request.
	function automatic alu_outcome_t alu_outcome(logic [OPCODE_W-1:0] op,
		logic [DW-1:0] a, logic [DW-1:0] b, logic [STATUS_W-1:0] st);
		alu_outcome_t  o;
		logic [DW:0]   sum;
		logic [DW-1:0] addend;
		logic          carry_in;
		logic          sign_zero_update;
		carry_in = st[FLAG_C];
		o.value = '0;
		o.writes = 1'b1;
		o.flags = st;
		sign_zero_update = 1'b1;
		case (op)
			ealu_pkg::OP_ADC, ealu_pkg::OP_SBC: begin
				// Subtract is an add of the inverted operand; carry enters either way.
				addend = (op == ealu_pkg::OP_SBC) ? ~b : b;
				sum = {1'b0, a} + {1'b0, addend} + carry_in;
				o.value = sum[DW-1:0];
				o.flags[FLAG_C] = sum[DW];
				o.flags[FLAG_V] = (a[DW-1] == addend[DW-1]) &&
					(o.value[DW-1] != a[DW-1]);
			end
			ealu_pkg::OP_AND: o.value = a & b;
			ealu_pkg::OP_XOR: o.value = a ^ b;
			ealu_pkg::OP_OR:  o.value = a | b;
			ealu_pkg::OP_CMP: begin
				// The difference is zero exactly when the operands are equal.
				o.value = a - b;
				o.writes = 1'b0;
				o.flags[FLAG_C] = (a >= b);
			end
			ealu_pkg::OP_ASL: begin
				o.value = {b[DW-2:0], 1'b0};
				o.flags[FLAG_C] = b[DW-1];
			end
			ealu_pkg::OP_LSR: begin
				o.value = {1'b0, b[DW-1:1]};
				o.flags[FLAG_C] = b[0];
			end
			ealu_pkg::OP_ROL: begin
				o.value = {b[DW-2:0], carry_in};
				o.flags[FLAG_C] = b[DW-1];
			end
			ealu_pkg::OP_ROR: begin
				o.value = {carry_in, b[DW-1:1]};
				o.flags[FLAG_C] = b[0];
			end
			ealu_pkg::OP_INC: o.value = b + 1'b1;
			ealu_pkg::OP_DEC: o.value = b - 1'b1;
			ealu_pkg::OP_SETF: begin
				o.writes = 1'b0;
				o.flags = st | b;
				sign_zero_update = 1'b0;
			end
			ealu_pkg::OP_CLRF: begin
				o.writes = 1'b0;
				o.flags = st & ~b;
				sign_zero_update = 1'b0;
			end
			ealu_pkg::OP_LDF: begin
				o.writes = 1'b0;
				o.value = b;
			end
			default: begin
				o.writes = 1'b0;
				sign_zero_update = 1'b0;
			end
		endcase
		if (sign_zero_update) begin
			o.flags[FLAG_N] = o.value[DW-1];
			o.flags[FLAG_Z] = (o.value == '0);
		end
		return o;
	endfunction

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// Sends one request. Starts and ends at a falling edge; valid stays high
	// between back-to-back requests and drops only for an idle burst.
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [DW-1:0] a,
		input logic [DW-1:0] b, input logic [STATUS_W-1:0] st);
		pending_request_t entry;
		if (idle_enabled && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		in_ch.status_in <= st;
		do
			@(posedge clk);
		while (!in_ch.ready);
		entry.op = op;
		entry.a = a;
		entry.b = b;
		entry.st = st;
		entry.outcome = alu_outcome(op, a, b, st);
		pending_outcomes.push_back(entry);
		@(negedge clk);
	endtask

	// Carry, zero and overflow corners of add and subtract.
	task automatic check_add_subtract_corners();
		send_request(ealu_pkg::OP_ADC, 8'hFF, 8'h01, 8'h00);
		send_request(ealu_pkg::OP_ADC, 8'h7F, 8'h00, 8'h3D);
		send_request(ealu_pkg::OP_ADC, 8'h80, 8'h80, 8'hC2);
		send_request(ealu_pkg::OP_SBC, 8'h00, 8'h01, 8'h01);
		send_request(ealu_pkg::OP_SBC, 8'h80, 8'h01, 8'h01);
		send_request(ealu_pkg::OP_SBC, 8'h50, 8'h50, 8'h00);
	endtask

	// Compare with the first operand below, equal to and above the second.
	task automatic check_compare_orderings();
		send_request(ealu_pkg::OP_CMP, 8'h01, 8'hFF, 8'h43);
		send_request(ealu_pkg::OP_CMP, 8'h80, 8'h80, 8'h80);
		send_request(ealu_pkg::OP_CMP, 8'hFF, 8'h00, 8'h02);
	endtask

	// Shifts and rotates replace the carry and rotates feed the old one in.
	task automatic check_shift_rotate_carry();
		send_request(ealu_pkg::OP_ASL, 8'h00, 8'h80, 8'h00);
		send_request(ealu_pkg::OP_LSR, 8'hFF, 8'h01, 8'h01);
		send_request(ealu_pkg::OP_ROL, 8'h00, 8'h80, 8'h01);
		send_request(ealu_pkg::OP_ROR, 8'h00, 8'h01, 8'h00);
		send_request(ealu_pkg::OP_ROR, 8'h00, 8'h00, 8'h01);
	endtask

	// Logic operations, and increment and decrement across the wrap.
	task automatic check_logic_inc_dec();
		send_request(ealu_pkg::OP_AND, 8'hF0, 8'h0F, 8'h80);
		send_request(ealu_pkg::OP_XOR, 8'hFF, 8'h00, 8'h42);
		send_request(ealu_pkg::OP_OR,  8'h00, 8'h00, 8'hFD);
		send_request(ealu_pkg::OP_INC, 8'h00, 8'hFF, 8'h80);
		send_request(ealu_pkg::OP_DEC, 8'hFF, 8'h00, 8'h02);
	endtask

	// Flag masks touch only the status byte; load sets sign and zero from b.
	task automatic check_flag_masks();
		send_request(ealu_pkg::OP_SETF, 8'hAA, 8'hFF, 8'h00);
		send_request(ealu_pkg::OP_CLRF, 8'h55, 8'hFF, 8'hFF);
		send_request(ealu_pkg::OP_LDF,  8'h00, 8'h80, 8'h02);
		send_request(ealu_pkg::OP_LDF,  8'hFF, 8'h00, 8'h80);
	endtask

	task automatic check_unused_opcode();
		send_request(OPCODE_UNUSED, 8'hFF, 8'hFF, 8'hA5);
	endtask

	// Operand values lean toward the sign and wrap boundaries now and then.
	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(0, 11))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h7F;
			3:       return 8'h80;
			default: return DW'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random_requests(input int count);
		logic [OPCODE_W-1:0] op;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 31) == 0)
				op = OPCODE_UNUSED;
			else
				op = OPCODE_W'($urandom_range(ealu_pkg::OP_ADC, ealu_pkg::OP_LDF));
			send_request(op, pick_operand(), pick_operand(),
				STATUS_W'($urandom_range(0, 255)));
		end
	endtask

	// Result side: ready drops in random bursts while idling is enabled.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enabled && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Compare every accepted result with the oldest pending request.
	always @(posedge clk) begin
		pending_request_t entry;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				note_failure($sformatf("unexpected result %02h/%0b/%02h with nothing pending",
					out_ch.result, out_ch.write_result, out_ch.status_out));
			end else begin
				entry = pending_outcomes.pop_front();
				if (out_ch.result !== entry.outcome.value ||
						out_ch.write_result !== entry.outcome.writes ||
						out_ch.status_out !== entry.outcome.flags)
					note_failure($sformatf({"mismatch op=%0d a=%02h b=%02h st=%02h: ",
						"expected %02h/%0b/%02h got %02h/%0b/%02h"},
						entry.op, entry.a, entry.b, entry.st, entry.outcome.value,
						entry.outcome.writes, entry.outcome.flags, out_ch.result,
						out_ch.write_result, out_ch.status_out));
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("eight_bit_alu_with_status_flags_tb: errors");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		error_count = 0;
		idle_enabled = 1'b1;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = ealu_pkg::OP_ADC;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		in_ch.status_in = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_add_subtract_corners();
		check_compare_orderings();
		check_shift_rotate_carry();
		check_logic_inc_dec();
		check_flag_masks();
		check_unused_opcode();
		run_random_requests(550);

		// Last part runs at full rate on both sides.
		idle_enabled = 1'b0;
		run_random_requests(100);
		in_ch.valid <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("eight_bit_alu_with_status_flags_tb: clean");
		else
			$display("eight_bit_alu_with_status_flags_tb: errors");
		$finish;
	end

endmodule
